// ===== src/ssm_pkg.sv =====
// Shared types and constants for the sorted set merge core.
package ssm_pkg;

  localparam logic [1:0] OP_PUSH_A = 2'd0;
  localparam logic [1:0] OP_PUSH_B = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  localparam logic [1:0] MODE_UNION = 2'd0;
  localparam logic [1:0] MODE_INTER = 2'd1;
  localparam logic [1:0] MODE_DIFF  = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [31:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  result_value;
    logic                last;
    logic                empty_res;
    logic                overflow;
  } out_item_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [31:0]  value;
  } cmd_t;

  typedef struct packed {
    logic  valid;
    cmd_t  cmd;
  } cmd_push_t;

endpackage

// ===== src/sorted_set_merge_operations_core.sv =====
// Top level of the sorted set merge core: front stage, command queue, back stage.
// Flow: a push passes through the front register and the queue before the back stage
// stores it; a run's results leave through the back stage's pending and output registers
// as the walk advances one or both store pointers at each step. Throughput: pushes at one
// per cycle while busy is low; a run occupies the back stage until its walk is done, while
// the queue takes commands until it is full. Results cannot be stalled.
// Reset (rst_n low, synchronous) empties both sets, the queue and the overflow flag.
module sorted_set_merge_operations_core import ssm_pkg::*; #(
  parameter int SET_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_item_t  out_item
);

  cmd_push_t q_push;
  logic      q_full;
  logic      q_nonempty;
  cmd_t      q_head;
  logic      q_pop;

  ssm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_full  (q_full),
    .q_push  (q_push)
  );

  ssm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  ssm_back #(
    .SET_CAPACITY (SET_CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule

// ===== src/ssm_front.sv =====
// Front stage: accepts commands, drops unused op codes, forwards to the queue.
module ssm_front import ssm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  in_item_t   in_item,
  output logic       busy,
  input  logic       q_full,
  output cmd_push_t  q_push
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic accept, fwd;

  assign busy   = valid_r && q_full;
  assign accept = start && !busy;
  assign fwd    = valid_r && !q_full;

  assign q_push.valid = fwd;
  assign q_push.cmd   = cmd_r;

  always_comb begin
    valid_nxt = valid_r && !fwd;
    cmd_nxt   = cmd_r;
    if (accept) begin
      cmd_nxt.kind  = in_item.op;
      cmd_nxt.value = in_item.value;
      valid_nxt     = (in_item.op == OP_PUSH_A) || (in_item.op == OP_PUSH_B) ||
                      (in_item.op == OP_RUN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// ===== src/ssm_queue.sv =====
// Short command queue between the front and back stages.
module ssm_queue import ssm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_push_t  q_push,
  output logic       q_full,
  output logic       q_nonempty,
  output cmd_t       q_head,
  input  logic       q_pop
);

  cmd_t entries_r [QDEPTH];
  logic [QAW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign q_full     = (cnt_r == QAW'(0) + (QAW+1)'(QDEPTH));
  assign q_nonempty = (cnt_r != '0);
  assign q_head     = entries_r[head_r];
  assign do_push    = q_push.valid && !q_full;
  assign do_pop     = q_pop && q_nonempty;

  always_comb begin
    head_nxt = do_pop  ? head_r + 1'b1 : head_r;
    tail_nxt = do_push ? tail_r + 1'b1 : tail_r;
    cnt_nxt  = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      entries_r[tail_r] <= q_push.cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");
  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !do_pop |=> q_full)
    else $error("queue left full state without a pop");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r - head_r) == cnt_r[QAW-1:0])
    else $error("queue pointers and count disagree");

endmodule

// ===== src/ssm_back.sv =====
// Back stage: set stores, counts, overflow flag and the two-pointer merge walk.
module ssm_back import ssm_pkg::*; #(
  parameter int SET_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       q_nonempty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int CW = $clog2(SET_CAPACITY + 1);
  localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [31:0] mem_a [SET_CAPACITY];
  logic [31:0] mem_b [SET_CAPACITY];

  logic          state_r, state_nxt;
  logic [1:0]    set_mode_r, run_mode_r, run_mode_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic          ovf_r, ovf_nxt;
  logic [31:0]   rd_a_r, rd_b_r;
  logic          pend_valid_r, pend_valid_nxt;
  logic [31:0]   pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;
  logic          wr_a, wr_b;
  logic          a_ok, b_ok, mode_ok, emit, done;
  logic [31:0]   emit_val;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign q_pop   = (state_r == ST_IDLE) && q_nonempty;
  assign wr_a    = q_pop && (q_head.kind == OP_PUSH_A) && (cnt_a_r < CAP);
  assign wr_b    = q_pop && (q_head.kind == OP_PUSH_B) && (cnt_b_r < CAP);
  assign a_ok    = ia_r < cnt_a_r;
  assign b_ok    = ib_r < cnt_b_r;
  assign mode_ok = (run_mode_r == MODE_UNION) || (run_mode_r == MODE_INTER) ||
                   (run_mode_r == MODE_DIFF);

  always_comb begin
    state_nxt      = state_r;
    run_mode_nxt   = run_mode_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    ovf_nxt        = ovf_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    emit           = 1'b0;
    emit_val       = rd_a_r;
    done           = 1'b0;

    if (state_r == ST_IDLE) begin
      if (q_pop) begin
        case (q_head.kind)
          OP_PUSH_A: begin
            if (wr_a) cnt_a_nxt = cnt_a_r + 1'b1;
            else      ovf_nxt   = 1'b1;
          end
          OP_PUSH_B: begin
            if (wr_b) cnt_b_nxt = cnt_b_r + 1'b1;
            else      ovf_nxt   = 1'b1;
          end
          OP_RUN: begin
            state_nxt    = ST_RUN;
            run_mode_nxt = set_mode_r;
          end
          default: begin
          end
        endcase
      end
    end else begin
      if (!mode_ok) begin
        done = 1'b1;
      end else if (a_ok && b_ok) begin
        if ($signed(rd_a_r) < $signed(rd_b_r)) begin
          emit     = (run_mode_r != MODE_INTER);
          emit_val = rd_a_r;
          ia_nxt   = ia_r + 1'b1;
        end else if ($signed(rd_a_r) > $signed(rd_b_r)) begin
          emit     = (run_mode_r == MODE_UNION);
          emit_val = rd_b_r;
          ib_nxt   = ib_r + 1'b1;
        end else begin
          emit     = (run_mode_r != MODE_DIFF);
          emit_val = rd_b_r;
          ia_nxt   = ia_r + 1'b1;
          ib_nxt   = ib_r + 1'b1;
        end
      end else if (a_ok && (run_mode_r == MODE_UNION || run_mode_r == MODE_DIFF)) begin
        emit     = 1'b1;
        emit_val = rd_a_r;
        ia_nxt   = ia_r + 1'b1;
      end else if (b_ok && (run_mode_r == MODE_UNION)) begin
        emit     = 1'b1;
        emit_val = rd_b_r;
        ib_nxt   = ib_r + 1'b1;
      end else begin
        done = 1'b1;
      end

      if (emit) begin
        if (pend_valid_r) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.result_value = pend_r;
          out_item_nxt.last         = 1'b0;
          out_item_nxt.empty_res    = 1'b0;
          out_item_nxt.overflow     = ovf_r;
        end
        pend_valid_nxt = 1'b1;
        pend_nxt       = emit_val;
      end

      if (done) begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.result_value = pend_valid_r ? pend_r : '0;
        out_item_nxt.last         = 1'b1;
        out_item_nxt.empty_res    = !pend_valid_r;
        out_item_nxt.overflow     = ovf_r;
        pend_valid_nxt            = 1'b0;
        cnt_a_nxt                 = '0;
        cnt_b_nxt                 = '0;
        ia_nxt                    = '0;
        ib_nxt                    = '0;
        ovf_nxt                   = 1'b0;
        state_nxt                 = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      set_mode_r   <= MODE_UNION;
      run_mode_r   <= MODE_UNION;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      ia_r         <= '0;
      ib_r         <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) set_mode_r <= cfg_wdata;
      run_mode_r   <= run_mode_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      ia_r         <= ia_nxt;
      ib_r         <= ib_nxt;
      ovf_r        <= ovf_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_a) mem_a[cnt_a_r[AW-1:0]] <= q_head.value;
    if (wr_b) mem_b[cnt_b_r[AW-1:0]] <= q_head.value;
    rd_a_r <= mem_a[ia_nxt[AW-1:0]];
    rd_b_r <= mem_b[ib_nxt[AW-1:0]];
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CAP && cnt_b_r <= CAP)
    else $error("set count beyond capacity");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && done |=> cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r)
    else $error("run end did not clear the sets");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.empty_res |-> out_item_r.last)
    else $error("empty result not marked last");
  a_idle_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> ia_r == '0 && ib_r == '0)
    else $error("walk pointers not at zero while idle");

endmodule

// ===== sim/tb_sorted_set_merge_operations_core.sv =====
// Testbench for the sorted set merge core: predicts union, intersection and difference runs.
`timescale 1ns / 1ps

module tb_sorted_set_merge_operations_core;
  import ssm_pkg::*;

  localparam int SET_CAP = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEMS_TARGET = 370;
  localparam int SETTLE_CYCLES = 2 * SET_CAP + 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  class merge_results;
    logic signed [31:0] store_a[SET_CAP];
    logic signed [31:0] store_b[SET_CAP];
    int unsigned cnt_a;
    int unsigned cnt_b;
    bit ovf;
    logic [1:0] mode;
    out_item_t pending[$];
    int n_fail;

    function void emit(logic signed [31:0] v, bit empty);
      out_item_t r;
      r.result_value = v;
      r.last = 1'b0;
      r.empty_res = empty;
      r.overflow = ovf;
      pending.push_back(r);
    endfunction

    function void run_merge();
      int unsigned i;
      int unsigned j;
      int n;
      i = 0;
      j = 0;
      n = 0;
      if (mode != MODE_UNUSED) begin
        while (i < cnt_a && j < cnt_b) begin
          if (store_a[i] < store_b[j]) begin
            if (mode != MODE_INTER) begin
              emit(store_a[i], 1'b0);
              n++;
            end
            i++;
          end else if (store_a[i] > store_b[j]) begin
            if (mode == MODE_UNION) begin
              emit(store_b[j], 1'b0);
              n++;
            end
            j++;
          end else begin
            if (mode != MODE_DIFF) begin
              emit(store_b[j], 1'b0);
              n++;
            end
            i++;
            j++;
          end
        end
        if (mode == MODE_UNION || mode == MODE_DIFF) begin
          while (i < cnt_a) begin
            emit(store_a[i], 1'b0);
            n++;
            i++;
          end
        end
        if (mode == MODE_UNION) begin
          while (j < cnt_b) begin
            emit(store_b[j], 1'b0);
            n++;
            j++;
          end
        end
      end
      if (n == 0) emit(32'sd0, 1'b1);
      pending[pending.size() - 1].last = 1'b1;
      cnt_a = 0;
      cnt_b = 0;
      ovf = 1'b0;
    endfunction

    function void record_command(in_item_t it);
      case (it.op)
        OP_PUSH_A: begin
          if (cnt_a < SET_CAP) begin
            store_a[cnt_a] = it.value;
            cnt_a++;
          end else begin
            ovf = 1'b1;
          end
        end
        OP_PUSH_B: begin
          if (cnt_b < SET_CAP) begin
            store_b[cnt_b] = it.value;
            cnt_b++;
          end else begin
            ovf = 1'b1;
          end
        end
        OP_RUN: run_merge();
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $error("result with nothing pending: result_value %0d", got.result_value);
        n_fail++;
        return;
      end
      exp = pending.pop_front();
      if (got.result_value !== exp.result_value) begin
        $error("result_value: expected %0d, got %0d", exp.result_value, got.result_value);
        n_fail++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last);
        n_fail++;
      end
      if (got.empty_res !== exp.empty_res) begin
        $error("empty_res: expected %0d, got %0d", exp.empty_res, got.empty_res);
        n_fail++;
      end
      if (got.overflow !== exp.overflow) begin
        $error("overflow: expected %0d, got %0d", exp.overflow, got.overflow);
        n_fail++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_wdata;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;

  merge_results sb;
  int sent;
  int idle_pct;
  int cycle_count = 0;
  int idle_levels[3] = '{0, 83, 25};

  sorted_set_merge_operations_core #(
    .SET_CAPACITY(SET_CAP)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_cmd(input logic [1:0] op, input logic signed [31:0] val);
    in_item_t it;
    it.op = op;
    it.value = val;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.record_command(it);
    if (op != OP_UNUSED) sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    sb.mode = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ascending pool split into A, B or both, so runs see matches and misses
  task automatic merge_sequence();
    longint lo;
    longint top;
    longint hi;
    longint base;
    longint v;
    longint unsigned rnd;
    int unsigned pool_n;
    int unsigned maxstep;
    int unsigned kind;
    int unsigned r;
    logic signed [31:0] qa[$];
    logic signed [31:0] qb[$];
    lo = -64'sd2147483648;
    top = 64'sd2147483647;
    pool_n = ($urandom_range(7) == 0) ? $urandom_range(40, 52) : $urandom_range(0, 10);
    kind = $urandom_range(3);
    maxstep = (kind == 0) ? 3 : 32'd33554432;
    hi = top - longint'(pool_n) * longint'(maxstep);
    rnd = {$urandom, $urandom};
    case (kind)
      0: base = longint'($urandom_range(40)) - 20;
      1: base = lo + longint'(rnd % longint'(hi - lo + 1));
      2: base = lo;
      default: base = hi;
    endcase
    v = base;
    for (int k = 0; k < pool_n; k++) begin
      r = $urandom_range(2);
      if (r != 1) qa.push_back(v[31:0]);
      if (r != 0) qb.push_back(v[31:0]);
      v = v + longint'($urandom_range(maxstep, 1));
    end
    while (qa.size() != 0 || qb.size() != 0) begin
      if ($urandom_range(19) == 0) send_cmd(OP_UNUSED, $urandom);
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(1) == 1))
        send_cmd(OP_PUSH_A, qa.pop_front());
      else
        send_cmd(OP_PUSH_B, qb.pop_front());
    end
    if ($urandom_range(5) != 0) send_cmd(OP_RUN, $urandom);
  endtask

  task automatic noise_sequence();
    repeat ($urandom_range(8, 1)) send_cmd(2'($urandom_range(3)), $urandom);
  endtask

  initial begin
    int phase;
    int seq_count;
    logic [1:0] m;
    sb = new;
    sent = 0;
    idle_pct = 0;
    phase = 0;
    seq_count = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 2'd0;
    start = 1'b0;
    in_item = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_mode(MODE_UNION);
    send_cmd(OP_PUSH_A, INT_MIN);
    send_cmd(OP_PUSH_A, -32'sd1);
    send_cmd(OP_PUSH_A, 32'sd0);
    send_cmd(OP_PUSH_A, INT_MAX);
    send_cmd(OP_PUSH_B, -32'sd1);
    send_cmd(OP_PUSH_B, 32'sd5);
    send_cmd(OP_PUSH_B, INT_MAX);
    send_cmd(OP_UNUSED, 32'shA5A5_5A5A);
    send_cmd(OP_RUN, 32'sd0);
    write_mode(MODE_INTER);
    send_cmd(OP_PUSH_A, 32'sd1);
    send_cmd(OP_PUSH_A, 32'sd2);
    send_cmd(OP_PUSH_A, 32'sd3);
    send_cmd(OP_PUSH_B, 32'sd2);
    send_cmd(OP_PUSH_B, 32'sd3);
    send_cmd(OP_PUSH_B, 32'sd4);
    send_cmd(OP_RUN, INT_MAX);
    write_mode(MODE_DIFF);
    send_cmd(OP_PUSH_A, -32'sd5);
    send_cmd(OP_PUSH_A, 32'sd2);
    send_cmd(OP_PUSH_B, 32'sd2);
    send_cmd(OP_RUN, INT_MIN);
    send_cmd(OP_RUN, 32'sd0);
    write_mode(MODE_UNUSED);
    send_cmd(OP_PUSH_A, 32'sd7);
    send_cmd(OP_PUSH_B, 32'sd7);
    send_cmd(OP_RUN, 32'sd0);

    while (sent < ITEMS_TARGET) begin
      if (seq_count % 6 == 0) begin
        m = (phase % 5 < 4) ? 2'(phase % 4) : 2'($urandom_range(3));
        idle_pct = idle_levels[phase % 3];
        write_mode(m);
        phase++;
      end
      if ($urandom_range(99) < 15) noise_sequence();
      else merge_sequence();
      seq_count++;
    end

    wait_drained();
    if (sb.n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
